// ===== hdl/tql_pkg.sv =====
`default_nettype none
package tql_pkg;

  // Field widths fixed by the item format
  localparam int ST_W  = 9;
  localparam int Q_W   = 32;
  localparam int CNT_W = 16;

  // Agent dimensions, tied to the field widths above
  localparam int NUM_STATES = 336;
  localparam int NEIGHBORS  = 8;
  localparam int HYS_STEPS  = 21;

  // Opcodes of an input item
  localparam logic [1:0] OP_WR_Q   = 2'd0;
  localparam logic [1:0] OP_WR_NB  = 2'd1;
  localparam logic [1:0] OP_WR_POL = 2'd2;
  localparam logic [1:0] OP_STEP   = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_WROTE = 2'd1;
  localparam logic [1:0] STAT_NO_NB = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_ALPHA = 2'd2;
  localparam logic [1:0] CFG_GAMMA = 2'd3;

  // Reward weights and the floor of the best-Q search (Q16.16)
  localparam int DROP_WEIGHT = 10;
  localparam int PING_WEIGHT = 2;
  localparam logic signed [37:0] MAXQ_FLOOR_Q = -38'sd999999 * 38'sd65536;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [ST_W-1:0]         row_state;
    logic [2:0]              slot;
    logic signed [Q_W-1:0]   q_word;
    logic [ST_W-1:0]         target_state;
    logic                    target_valid;
    logic [CNT_W-1:0]        handover_count;
    logic [CNT_W-1:0]        drop_count;
    logic [CNT_W-1:0]        pingpong_count;
    logic [2:0]              random_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [ST_W-1:0]         new_state;
    logic [3:0]              trigger_index;
    logic [4:0]              hysteresis_index;
    logic signed [Q_W-1:0]   updated_q;
    logic [ST_W-1:0]         greedy_choice;
  } out_item_t;

  // Operands of one Q update
  typedef struct packed {
    logic [CNT_W-1:0]        handover_count;
    logic [CNT_W-1:0]        drop_count;
    logic [CNT_W-1:0]        pingpong_count;
    logic signed [37:0]      best;
    logic signed [Q_W-1:0]   old;
    logic [15:0]             alpha;
    logic [15:0]             gamma;
  } qc_req_t;

endpackage
`default_nettype wire

// ===== hdl/tql_qcalc.sv =====
`default_nettype none
module tql_qcalc import tql_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           go,
  input  wire qc_req_t        req,
  output logic                done,
  output logic signed [31:0]  nv
);

  logic [3:0]          vld_r;
  logic signed [21:0]  rwd_r;
  logic signed [54:0]  gprod_r;
  logic signed [31:0]  old_r;
  logic [15:0]         alpha_r;
  logic signed [39:0]  td_r;
  logic signed [56:0]  aprod_r;
  logic signed [31:0]  nv_r;

  logic [19:0]         pen;
  logic signed [21:0]  rwd;
  logic signed [54:0]  gprod;
  logic signed [54:0]  gsum;
  logic signed [54:0]  gsh;
  logic signed [39:0]  td;
  logic signed [56:0]  aprod;
  logic signed [56:0]  asum;
  logic signed [56:0]  ash;
  logic signed [42:0]  nvw;

  // Stage 1: reward and gamma * maxQ
  always_comb begin
    pen   = 20'(req.drop_count) * 20'(DROP_WEIGHT) + 20'(req.pingpong_count) * 20'(PING_WEIGHT);
    rwd   = $signed(22'(req.handover_count)) - $signed(22'(pen));
    gprod = $signed({1'b0, req.gamma}) * req.best;
  end

  // Stage 2: round gamma term, form temporal difference
  always_comb begin
    gsum = gprod_r + 55'sd32768;
    gsh  = gsum >>> 16;
    td   = (40'(rwd_r) <<< 16) + $signed(gsh[39:0]) - 40'(old_r);
  end

  // Stage 3: alpha * difference
  assign aprod = $signed({1'b0, alpha_r}) * td_r;

  // Stage 4: round, add, saturate
  always_comb begin
    asum = aprod_r + 57'sd32768;
    ash  = asum >>> 16;
    nvw  = 43'(old_r) + $signed(ash[42:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], go};
    end
  end

  always_ff @(posedge clk) begin
    rwd_r   <= rwd;
    gprod_r <= gprod;
    if (go) begin
      old_r   <= req.old;
      alpha_r <= req.alpha;
    end
    td_r    <= td;
    aprod_r <= aprod;
    if (nvw > 43'sd2147483647) begin
      nv_r <= 32'sh7FFFFFFF;
    end else if (nvw < -43'sd2147483648) begin
      nv_r <= 32'sh80000000;
    end else begin
      nv_r <= $signed(nvw[31:0]);
    end
  end

  assign done = vld_r[3];
  assign nv   = nv_r;

endmodule
`default_nettype wire

// ===== hdl/tabular_q_learning_agent_top.sv =====
`default_nettype none
// Tabular Q-learning agent for handover parameter tuning.
// Input channel: an item is taken on a clock edge with start high and busy
// low. Opcodes 0..2 write the Q, neighbor or policy table; opcode 3 runs
// one learning step from the present state.
// Result channel: out_strobe is high for one cycle with out_data; every
// item gives exactly one result. The receiver cannot stall and need not.
// Configuration: cfg_we with cfg_index/cfg_wdata, written while idle.
// Table write: its result leaves after the S_DIV and S_FIN states,
// and the next item can be taken on the edge that ends the result cycle.
// A step walks the state's neighbor row in up to three passes over the
// single-read-port tables, plus a Q update (four pipeline stages and the
// write-back) and the S_DIV and S_FIN states to split and register the
// result. busy is high during that time; one item is in flight.
// Reset: control state clears, present state 0, first step pending,
// alpha 0.5 and gamma 0.9. The table memories are not cleared and must
// be loaded before a step reads them.
module tabular_q_learning_agent_top import tql_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_strobe,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int SLOT_W  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int CW      = $clog2(NEIGHBORS + 1);
  localparam int DEPTH   = NUM_STATES * NEIGHBORS;
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = $clog2(NUM_STATES);
  localparam int DIV_K   = 18;
  localparam int RECIP   = (1 << DIV_K) / HYS_STEPS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [1:0] PASS_A = 2'd0;  // max Q and action lookup
  localparam logic [1:0] PASS_B = 2'd1;  // greedy search, after the update if any
  localparam logic [1:0] PASS_C = 2'd2;  // exploration slot search

  function automatic logic [8:0] fold_state(input logic [8:0] s);
    return (32'(s) >= NUM_STATES) ? 9'(NUM_STATES - 1) : s;
  endfunction

  function automatic logic [SLOT_W-1:0] wrap_rand(input logic [2:0] r);
    logic [4:0] v;
    v = {2'b00, r};
    for (int i = 0; i < 8; i++) begin
      if (32'(v) >= NEIGHBORS) v = v - 5'(NEIGHBORS);
    end
    return SLOT_W'(v);
  endfunction

  // Memories
  logic signed [31:0] q_mem  [DEPTH];
  logic [9:0]         nb_mem [DEPTH];
  logic [8:0]         pol_mem[NUM_STATES];

  logic [2:0]          state_r;
  logic [1:0]          pass_r;
  in_item_t            item_r;
  logic [8:0]          s_r, present_r, pending_r, nxt_r, ns_r;
  logic [SLOT_W-1:0]   taken_r, uslot_r, issue_slot_r, tag_slot_r;
  logic                first_r, mode_r;
  logic [15:0]         alpha_r, gamma_r;
  logic [CW-1:0]       cnt_r;
  logic                tag_v_r, tag_last_r;
  logic signed [31:0]  q_rd_r;
  logic [9:0]          nb_rd_r;
  logic [8:0]          pol_rd_r;
  logic                qc_go_r;
  logic [1:0]          status_r;
  logic signed [31:0]  qv_r;
  logic [8:0]          greedy_r;
  logic [8:0]          q0_r;
  logic                out_strobe_r;
  out_item_t           out_data_r;

  // Scan accumulators
  logic                mfound_r, any_r, hit_r, gfound_r, found_r;
  logic signed [31:0]  max_r, old_r, gmax_r;
  logic [SLOT_W-1:0]   hslot_r, fslot_r;
  logic [8:0]          gsel_r, ftgt_r;
  logic                mfound_nxt, any_nxt, hit_nxt, gfound_nxt, found_nxt;
  logic signed [31:0]  max_nxt, old_nxt, gmax_nxt;
  logic [SLOT_W-1:0]   hslot_nxt, fslot_nxt;
  logic [8:0]          gsel_nxt, ftgt_nxt;

  logic                issue, accept, wr_ok, end_a, end_b, end_c, pol_upd;
  logic [8:0]          rd_row;
  logic [AW-1:0]       rd_addr, wr_addr, upd_addr;
  logic                nb_v;
  logic [8:0]          nb_t;
  logic [SLOT_W-1:0]   slot_next;
  logic                qc_done;
  logic signed [31:0]  qc_nv;
  qc_req_t             qc_req;
  logic [15:0]         rem0, rem_fin;
  logic [8:0]          q_fin;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign wr_ok   = (32'(in_data.row_state) < NUM_STATES) && (32'(in_data.slot) < NEIGHBORS);
  assign issue   = (state_r == S_SCAN) && (32'(cnt_r) < NEIGHBORS);
  assign rd_row  = (pass_r == PASS_C) ? present_r : s_r;
  assign rd_addr = AW'(32'(rd_row) * NEIGHBORS + 32'(issue_slot_r));
  assign wr_addr = AW'(32'(in_data.row_state) * NEIGHBORS + 32'(SLOT_W'(in_data.slot)));
  assign upd_addr = AW'(32'(s_r) * NEIGHBORS + 32'(uslot_r));
  assign slot_next = (32'(issue_slot_r) == NEIGHBORS - 1) ? '0 : issue_slot_r + 1'b1;
  assign nb_v    = nb_rd_r[9];
  assign nb_t    = nb_rd_r[8:0];
  assign end_a   = (state_r == S_SCAN) && tag_last_r && (pass_r == PASS_A);
  assign end_b   = (state_r == S_SCAN) && tag_last_r && (pass_r == PASS_B);
  assign end_c   = (state_r == S_SCAN) && tag_last_r && (pass_r == PASS_C);
  assign pol_upd = end_b && mode_r && gfound_nxt;

  // Fold one returned neighbor entry into the pass accumulators
  always_comb begin
    mfound_nxt = mfound_r; max_nxt = max_r; any_nxt = any_r;
    hit_nxt = hit_r; hslot_nxt = hslot_r; old_nxt = old_r;
    gfound_nxt = gfound_r; gmax_nxt = gmax_r; gsel_nxt = gsel_r;
    found_nxt = found_r; fslot_nxt = fslot_r; ftgt_nxt = ftgt_r;
    if (tag_v_r) begin
      case (pass_r)
        PASS_A: begin
          if (nb_v && (!mfound_r || q_rd_r > max_r)) begin
            max_nxt = q_rd_r;
            mfound_nxt = 1'b1;
          end
          any_nxt = any_r | nb_v;
          if (mode_r) begin
            if (nb_v && !hit_r && nb_t == pol_rd_r) begin
              hit_nxt = 1'b1;
              hslot_nxt = tag_slot_r;
              old_nxt = q_rd_r;
            end
          end else if (tag_slot_r == taken_r) begin
            old_nxt = q_rd_r;
          end
        end
        PASS_B: begin
          if (nb_v && (!gfound_r || q_rd_r > gmax_r)) begin
            gmax_nxt = q_rd_r;
            gsel_nxt = nb_t;
            gfound_nxt = 1'b1;
          end
        end
        PASS_C: begin
          if (nb_v && !found_r) begin
            found_nxt = 1'b1;
            fslot_nxt = tag_slot_r;
            ftgt_nxt = nb_t;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Q update operands
  always_comb begin
    qc_req.handover_count = item_r.handover_count;
    qc_req.drop_count     = item_r.drop_count;
    qc_req.pingpong_count = item_r.pingpong_count;
    qc_req.best           = mfound_r ? 38'(max_r) : MAXQ_FLOOR_Q;
    qc_req.old            = old_r;
    qc_req.alpha          = alpha_r;
    qc_req.gamma          = gamma_r;
  end

  tql_qcalc u_qcalc (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (qc_go_r),
    .req   (qc_req),
    .done  (qc_done),
    .nv    (qc_nv)
  );

  // Q table: load writes, update write-back, one read port
  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == OP_WR_Q && wr_ok) begin
      q_mem[wr_addr] <= in_data.q_word;
    end else if (state_r == S_CALC && qc_done) begin
      q_mem[upd_addr] <= qc_nv;
    end
    q_rd_r <= q_mem[rd_addr];
  end

  // Neighbor table
  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == OP_WR_NB && wr_ok) begin
      nb_mem[wr_addr] <= {in_data.target_valid, fold_state(in_data.target_state)};
    end
    nb_rd_r <= nb_mem[rd_addr];
  end

  // Policy table
  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == OP_WR_POL && (32'(in_data.row_state) < NUM_STATES)) begin
      pol_mem[in_data.row_state[PW-1:0]] <= fold_state(in_data.target_state);
    end else if (pol_upd) begin
      pol_mem[s_r[PW-1:0]] <= gsel_nxt;
    end
    pol_rd_r <= pol_mem[present_r[PW-1:0]];
  end

  // Split of the new state into trigger and hysteresis indexes
  always_comb begin
    rem0 = 16'(ns_r) - 16'(32'(q0_r) * HYS_STEPS);
    if (32'(rem0) >= HYS_STEPS) begin
      q_fin   = q0_r + 9'd1;
      rem_fin = rem0 - 16'(HYS_STEPS);
    end else begin
      q_fin   = q0_r;
      rem_fin = rem0;
    end
  end

  // Payload registers of the step
  always_ff @(posedge clk) begin
    mfound_r <= mfound_nxt; max_r <= max_nxt; any_r <= any_nxt;
    hit_r <= hit_nxt; hslot_r <= hslot_nxt; old_r <= old_nxt;
    gfound_r <= gfound_nxt; gmax_r <= gmax_nxt; gsel_r <= gsel_nxt;
    found_r <= found_nxt; fslot_r <= fslot_nxt; ftgt_r <= ftgt_nxt;
    tag_slot_r <= issue_slot_r;
    if (accept) begin
      item_r <= in_data;
      s_r <= present_r;
      mfound_r <= 1'b0; any_r <= 1'b0; hit_r <= 1'b0;
      gfound_r <= 1'b0; found_r <= 1'b0;
      qv_r <= '0; greedy_r <= '0;
      ns_r <= present_r;
      status_r <= (in_data.opcode == OP_STEP) ? STAT_DONE : STAT_WROTE;
    end
    if (end_a) begin
      nxt_r <= pol_rd_r;
      uslot_r <= mode_r ? hslot_nxt : taken_r;
    end
    if (state_r == S_CALC && qc_done) begin
      qv_r <= qc_nv;
    end
    if (end_b) begin
      greedy_r <= gfound_nxt ? gsel_nxt : 9'd0;
      if (mode_r) begin
        ns_r <= nxt_r;
        status_r <= any_r ? STAT_DONE : STAT_NO_NB;
      end
    end
    if (end_c) begin
      if (found_nxt) begin
        ns_r <= ftgt_nxt;
      end else begin
        ns_r <= present_r;
        status_r <= STAT_NO_NB;
      end
    end
    if (state_r == S_DIV) begin
      q0_r <= 9'((32'(ns_r) * RECIP) >> DIV_K);
    end
    if (state_r == S_FIN) begin
      out_data_r.status           <= status_r;
      out_data_r.new_state        <= ns_r;
      out_data_r.trigger_index    <= 4'(q_fin);
      out_data_r.hysteresis_index <= 5'(rem_fin);
      out_data_r.updated_q        <= qv_r;
      out_data_r.greedy_choice    <= greedy_r;
    end
  end

  // Control: sequencer, agent state, configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r <= PASS_A;
      cnt_r <= '0;
      issue_slot_r <= '0;
      tag_v_r <= 1'b0;
      tag_last_r <= 1'b0;
      qc_go_r <= 1'b0;
      out_strobe_r <= 1'b0;
      present_r <= '0;
      pending_r <= '0;
      taken_r <= '0;
      first_r <= 1'b1;
      mode_r <= 1'b0;
      alpha_r <= 16'd32768;
      gamma_r <= 16'd58982;
    end else begin
      out_strobe_r <= 1'b0;
      qc_go_r <= 1'b0;
      tag_v_r <= issue;
      tag_last_r <= issue && (32'(cnt_r) == NEIGHBORS - 1);
      if (issue) begin
        cnt_r <= cnt_r + 1'b1;
        issue_slot_r <= slot_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:  mode_r <= cfg_wdata[0];
          CFG_START: begin
            present_r <= fold_state(cfg_wdata[8:0]);
            first_r <= 1'b1;
          end
          CFG_ALPHA: alpha_r <= cfg_wdata;
          CFG_GAMMA: gamma_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_data.opcode == OP_STEP) begin
              state_r <= S_SCAN;
              pass_r <= PASS_A;
              cnt_r <= '0;
              issue_slot_r <= '0;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_SCAN: begin
          if (end_a) begin
            if (mode_r) begin
              if (hit_nxt) taken_r <= hslot_nxt;
            end else begin
              if (!first_r) present_r <= pending_r;
              first_r <= 1'b0;
            end
            if (mode_r ? hit_nxt : !first_r) begin
              state_r <= S_CALC;
              qc_go_r <= 1'b1;
            end else begin
              pass_r <= PASS_B;
              cnt_r <= '0;
              issue_slot_r <= '0;
            end
          end
          if (end_b) begin
            if (mode_r) begin
              present_r <= nxt_r;
              pending_r <= nxt_r;
              first_r <= 1'b1;
              state_r <= S_DIV;
            end else begin
              pass_r <= PASS_C;
              cnt_r <= '0;
              issue_slot_r <= wrap_rand(item_r.random_slot);
            end
          end
          if (end_c) begin
            if (found_nxt) begin
              taken_r <= fslot_nxt;
              pending_r <= ftgt_nxt;
            end else begin
              pending_r <= present_r;
              first_r <= 1'b1;
            end
            state_r <= S_DIV;
          end
        end
        S_CALC: begin
          if (qc_done) begin
            state_r <= S_SCAN;
            pass_r <= PASS_B;
            cnt_r <= '0;
            issue_slot_r <= '0;
          end
        end
        S_DIV: state_r <= S_FIN;
        S_FIN: begin
          out_strobe_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef NO_ASSERTIONS
  // A result only ever leaves after the sequencer has gone idle again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer active");

  // The update pipeline finishes only while the sequencer waits on it
  a_calc_done: assert property (@(posedge clk) disable iff (!rst_n)
    qc_done |-> (state_r == S_CALC))
    else $error("Q update completed outside its wait state");

  // Memory read data only arrives during a scan pass
  a_tag_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tag_v_r |-> (state_r == S_SCAN))
    else $error("scan data returned outside a scan");

  // The agent never sits on an out-of-range state
  a_present_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(present_r) < NUM_STATES) && (32'(pending_r) < NUM_STATES))
    else $error("agent state out of range");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_tabular_q_learning_agent_top.sv =====
`default_nettype none
module tb_tabular_q_learning_agent_top import tql_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ST   = 336;
  localparam int NB       = 8;
  localparam int HYS      = 21;
  localparam int STALL_LIM = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_strobe;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MODE;
  logic [15:0] cfg_wdata = '0;

  tabular_q_learning_agent_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Agent mirror: tables, walk state and registers
  longint q_tab [NUM_ST*NB];
  bit     nb_ok [NUM_ST*NB];
  int     nb_dst[NUM_ST*NB];
  int     pol_tab[NUM_ST];
  int     cur_st, nxt_st, act_slot;
  bit     fresh_walk;
  int     m_mode, m_alpha, m_gamma;

  in_item_t  item_q[$];
  out_item_t want_q[$];
  int idle_pct = 0;
  int n_steps = 0, n_writes = 0, n_no_nb = 0, n_sat = 0;
  int n_bad = 0, n_out = 0;

  // Append one item to the stimulus queue
  function automatic void queue_item(in_item_t it);
    item_q.insert(item_q.size(), it);
  endfunction

  function automatic int fold_st(int s);
    return (s < NUM_ST) ? s : NUM_ST - 1;
  endfunction

  function automatic longint rnd_q16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic longint row_best(int r);
    longint m = -64'sd999999 * 64'sd65536;
    for (int i = 0; i < NB; i++)
      if (nb_ok[r*NB+i] && q_tab[r*NB+i] > m) m = q_tab[r*NB+i];
    return m;
  endfunction

  // Greedy neighbor of a row; found is 0 when no slot beats the floor
  function automatic int row_greedy(int r, output bit found);
    longint m = -64'sd99999 * 64'sd65536;
    int c = 0;
    found = 0;
    for (int i = 0; i < NB; i++)
      if (nb_ok[r*NB+i] && q_tab[r*NB+i] > m) begin
        m = q_tab[r*NB+i];
        c = nb_dst[r*NB+i];
        found = 1;
      end
    return c;
  endfunction

  function automatic longint q_update(int r, int s, in_item_t it);
    int     idx = r*NB + s;
    longint old = q_tab[idx];
    longint rw, gm, td, nv;
    rw = longint'(it.handover_count) -
         (longint'(DROP_WEIGHT) * longint'(it.drop_count) +
          longint'(PING_WEIGHT) * longint'(it.pingpong_count));
    gm = rnd_q16(longint'(m_gamma) * row_best(r));
    td = rw * 64'sd65536 + gm - old;
    nv = old + rnd_q16(longint'(m_alpha) * td);
    if (nv > 64'sd2147483647) begin nv = 64'sd2147483647; n_sat++; end
    if (nv < -64'sd2147483648) begin nv = -64'sd2147483648; n_sat++; end
    q_tab[idx] = nv;
    return nv;
  endfunction

  // Advance the mirror by one item and return the result it yields
  function automatic out_item_t agent_step(in_item_t it);
    out_item_t o;
    int r = int'(it.row_state), sl = int'(it.slot), ns = 0, gr = 0, st, fnd, nx;
    longint qv = 0;
    bit gf, any, hit;
    logic [1:0] stat = STAT_DONE;
    if (it.opcode != OP_STEP) begin
      n_writes++;
      if (r < NUM_ST) begin
        case (it.opcode)
          OP_WR_Q:  q_tab[r*NB+sl] = longint'(it.q_word);
          OP_WR_NB: begin
            nb_dst[r*NB+sl] = fold_st(int'(it.target_state));
            nb_ok[r*NB+sl]  = it.target_valid;
          end
          default:  pol_tab[r] = fold_st(int'(it.target_state));
        endcase
      end
      stat = STAT_WROTE;
      ns = cur_st;
    end else if (m_mode == 0) begin
      n_steps++;
      st = cur_st;
      fnd = NB;
      if (!fresh_walk) begin
        qv = q_update(st, act_slot, it);
        cur_st = nxt_st;
      end
      fresh_walk = 0;
      gr = row_greedy(st, gf);
      for (int i = 0; i < NB; i++) begin
        int k = (int'(it.random_slot) + i) % NB;
        if (fnd == NB && nb_ok[cur_st*NB+k]) fnd = k;
      end
      if (fnd < NB) begin
        act_slot = fnd;
        nxt_st = nb_dst[cur_st*NB+fnd];
      end else begin
        stat = STAT_NO_NB;
        nxt_st = cur_st;
        fresh_walk = 1;
      end
      ns = nxt_st;
    end else begin
      n_steps++;
      st = cur_st;
      nx = pol_tab[st];
      any = 0;
      hit = 0;
      for (int i = 0; i < NB; i++)
        if (nb_ok[st*NB+i]) begin
          any = 1;
          if (!hit && nb_dst[st*NB+i] == nx) begin
            hit = 1;
            act_slot = i;
          end
        end
      if (hit) qv = q_update(st, act_slot, it);
      gr = row_greedy(st, gf);
      if (gf) pol_tab[st] = gr;
      if (!any) stat = STAT_NO_NB;
      cur_st = nx;
      nxt_st = nx;
      fresh_walk = 1;
      ns = nx;
    end
    if (stat == STAT_NO_NB) n_no_nb++;
    o.status           = stat;
    o.new_state        = 9'(ns);
    o.trigger_index    = 4'(ns / HYS);
    o.hysteresis_index = 5'(ns % HYS);
    o.updated_q        = qv[31:0];
    o.greedy_choice    = 9'(gr);
    return o;
  endfunction

  // Driver: present queued items, idle at random between transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) want_q.insert(want_q.size(), agent_step(in_data));
      if (!start || !busy) begin
        if (item_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start   <= 1'b1;
          in_data <= item_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_strobe) begin
      n_out++;
      if (want_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %p", out_data);
      end else begin
        w = want_q.pop_front();
        if (out_data.status !== w.status || out_data.new_state !== w.new_state ||
            out_data.trigger_index !== w.trigger_index ||
            out_data.hysteresis_index !== w.hysteresis_index ||
            out_data.updated_q !== w.updated_q ||
            out_data.greedy_choice !== w.greedy_choice) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch at result %0d: expected %p, got %p", n_out, w, out_data);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  int stall = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) begin
      stall <= 0;
    end else if (stall >= STALL_LIM) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  // Walk states: rows 0..13 plus 334 and 335, always fully loaded
  function automatic int member(int k);
    return (k < 14) ? k : 320 + k;
  endfunction

  function automatic int walk_dst();
    return ($urandom_range(9) == 0) ? int'($urandom_range(511, 335))
                                    : member(int'($urandom_range(15)));
  endfunction

  function automatic logic [15:0] count_val();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(40));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t raw_item();
    logic [127:0] raw = {$urandom, $urandom, $urandom, $urandom};
    in_item_t it;
    it = raw[$bits(in_item_t)-1:0];
    it.handover_count = count_val();
    it.drop_count     = count_val();
    it.pingpong_count = count_val();
    return it;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] op, int row, int sl, int dst, bit ok,
                                       logic [31:0] qw);
    in_item_t it = raw_item();
    it.opcode = op;
    it.row_state = 9'(row);
    it.slot = 3'(sl);
    it.target_state = 9'(dst);
    it.target_valid = ok;
    it.q_word = qw;
    return it;
  endfunction

  function automatic in_item_t mk_step();
    in_item_t it = raw_item();
    it.opcode = OP_STEP;
    return it;
  endfunction

  // Mostly steps and well-formed loads of walk rows, some noise writes elsewhere
  function automatic in_item_t rand_item();
    int p = $urandom_range(99);
    int nr;
    if (p < 60) return mk_step();
    if (p < 75) return mk_item(OP_WR_NB, member($urandom_range(15)), $urandom_range(7),
                               walk_dst(), $urandom_range(9) < 7, $urandom);
    if (p < 85) return mk_item(OP_WR_Q, member($urandom_range(15)), $urandom_range(7),
                               walk_dst(), $urandom_range(1) == 1,
                               $urandom_range(3) == 0 ? $urandom : $signed($urandom) >>> 12);
    if (p < 90) return mk_item(OP_WR_POL, member($urandom_range(15)), $urandom_range(7),
                               walk_dst(), $urandom_range(1) == 1, $urandom);
    nr = $urandom_range(1) ? $urandom_range(333, 14) : $urandom_range(511, 336);
    return mk_item(2'($urandom_range(2)), nr, $urandom_range(7), $urandom_range(511),
                   $urandom_range(1) == 1, $urandom);
  endfunction

  task automatic drain();
    while (item_q.size() > 0 || want_q.size() > 0 || start || busy) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MODE:  m_mode = int'(val[0]);
      CFG_START: begin
        cur_st = fold_st(int'(val[8:0]));
        fresh_walk = 1;
      end
      CFG_ALPHA: m_alpha = int'(val);
      default:   m_gamma = int'(val);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int md, int ss, int al, int gm);
    drain();
    write_reg(CFG_MODE, 16'(md));
    write_reg(CFG_START, 16'(ss));
    write_reg(CFG_ALPHA, 16'(al));
    write_reg(CFG_GAMMA, 16'(gm));
  endtask

  int settings[6][4] = '{'{0, 0, 32768, 58982}, '{1, 335, 65535, 65535},
                         '{0, 511, 0, 0}, '{1, 5, 12345, 40000},
                         '{0, 334, 65535, 0}, '{1, 13, 1, 65535}};
  int idle_of[3] = '{19, 73, 0};

  initial begin
    int row;
    cur_st = 0; nxt_st = 0; act_slot = 0; fresh_walk = 1;
    m_mode = 0; m_alpha = 32768; m_gamma = 58982;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Load every walk row; row 13 has no valid neighbor
    for (int k = 0; k < 16; k++) begin
      row = member(k);
      for (int s = 0; s < NB; s++) begin
        queue_item(mk_item(OP_WR_NB, row, s, member($urandom_range(15)),
                           row != 13 && $urandom_range(3) != 0, 0));
        queue_item(mk_item(OP_WR_Q, row, s, 0, 0, $signed($urandom) >>> 10));
      end
      queue_item(mk_item(OP_WR_POL, row, 0, member($urandom_range(15)), 0, 0));
    end

    // Directed: Q extremes, saturating targets, ignored rows, reward extremes
    queue_item(mk_item(OP_WR_Q, 0, 0, 0, 0, 32'h7FFFFFFF));
    queue_item(mk_item(OP_WR_Q, 0, 1, 0, 0, 32'h80000000));
    queue_item(mk_item(OP_WR_NB, 0, 0, 335, 1, 0));
    queue_item(mk_item(OP_WR_NB, 0, 1, 511, 1, 0));
    queue_item(mk_item(OP_WR_NB, 335, 7, 0, 1, 0));
    queue_item(mk_item(OP_WR_POL, 334, 0, 400, 0, 0));
    queue_item(mk_item(OP_WR_Q, 511, 7, 511, 1, 32'hFFFFFFFF));
    queue_item(mk_item(OP_WR_NB, 336, 3, 7, 1, 0));
    queue_item(mk_item(OP_WR_POL, 450, 0, 1, 1, 0));
    for (int i = 0; i < 6; i++) begin
      in_item_t it;
      it = mk_step();
      it.handover_count = (i % 2) ? 16'hFFFF : 16'd0;
      it.drop_count     = (i % 3 == 0) ? 16'hFFFF : 16'd0;
      it.pingpong_count = (i > 3) ? 16'hFFFF : 16'd0;
      it.random_slot    = 3'(i);
      queue_item(it);
    end
    set_regs(0, 13, 65535, 65535);
    queue_item(mk_step());
    queue_item(mk_step());
    set_regs(1, 13, 32768, 58982);
    queue_item(mk_step());
    set_regs(1, 0, 65535, 65535);
    for (int i = 0; i < 4; i++) queue_item(mk_step());

    // Random phases, two register settings each
    for (int p = 0; p < 3; p++) begin
      for (int h = 0; h < 2; h++) begin
        set_regs(settings[2*p+h][0], settings[2*p+h][1],
                 settings[2*p+h][2], settings[2*p+h][3]);
        idle_pct = idle_of[p];
        for (int i = 0; i < 220; i++) queue_item(rand_item());
      end
    end
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d steps and %0d table writes, %0d without a valid neighbor,",
             n_steps, n_writes, n_no_nb);
    $display("%0d saturated Q updates, over six register settings and three idle mixes",
             n_sat);
    if (n_bad == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/tql_pkg.sv
hdl/tql_qcalc.sv
hdl/tabular_q_learning_agent_top.sv
verif/tb_tabular_q_learning_agent_top.sv
